### rtl/spot_pkg.sv
`default_nettype none

package spot_pkg;

   // Field widths fixed by the stream format
   localparam int SYM_W      = 8;
   localparam int POS_W      = 20;
   localparam int COUNT_W    = 21;
   localparam int CFG_W      = 21;
   localparam int EPOCH_W    = 16;

   localparam int MAX_BLOCK_DEF   = 1048576;
   localparam int SYMBOL_BITS_DEF = 8;
   localparam int CFG_RESET       = 1048576;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

   // Result status codes
   typedef enum logic [1:0] {
      PS_NONE   = 2'd0,
      PS_FIRST  = 2'd1,
      PS_ACTIVE = 2'd2,
      PS_MORE   = 2'd3
   } pair_status_type;

   // One pair table entry; tag marks the block it belongs to
   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic               seen;
      logic               active;
      logic [POS_W-1:0]   pos;
      logic [COUNT_W-1:0] count;
   } pair_entry_type;

   // Status of the table sweep sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic wr_en;
      logic rd_en;
   } sweep_stat_type;

endpackage

`default_nettype wire

### rtl/spot_pair_ram.sv
`default_nettype none

module spot_pair_ram
   import spot_pkg::*;
#(
   parameter int ADDR_W = 2 * SYMBOL_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire pair_entry_type      wr_data,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output pair_entry_type           rd_data
);

   pair_entry_type mem [2**ADDR_W];
   pair_entry_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/spot_sweep.sv
`default_nettype none

module spot_sweep
   import spot_pkg::*;
#(
   parameter int ADDR_W = 2 * SYMBOL_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire pair_entry_type      rd_data,
   output sweep_stat_type           stat,
   output logic [ADDR_W-1:0]        rd_addr,
   output logic [ADDR_W-1:0]        wr_addr,
   output pair_entry_type           wr_data
);

   typedef enum logic [2:0] {
      SW_IDLE    = 3'b001,
      SW_INIT    = 3'b010,
      SW_RELABEL = 3'b100
   } sweep_state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR = {ADDR_W{1'b1}};

   sweep_state_type   state_ff, state_in;
   logic [ADDR_W:0]   cnt_ff, cnt_in;
   logic              wpend_ff, wpend_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   pair_entry_type    relabel;

   // Entries of the current block keep it as block one, all others go stale
   always_comb begin
      relabel     = rd_data;
      relabel.tag = (rd_data.tag == EPOCH_MAX) ? EPOCH_ONE : '0;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      wpend_in    = 1'b0;
      waddr_in    = waddr_ff;
      stat        = '0;
      rd_addr     = cnt_ff[ADDR_W-1:0];
      wr_addr     = waddr_ff;
      wr_data     = relabel;
      case (state_ff)
         SW_IDLE: begin
            if (start) begin
               state_in = SW_RELABEL;
               cnt_in   = '0;
            end
         end
         SW_INIT: begin
            // write-only pass: contents are unknown after reset
            stat.busy  = 1'b1;
            stat.wr_en = 1'b1;
            wr_addr    = cnt_ff[ADDR_W-1:0];
            wr_data    = '0;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff[ADDR_W-1:0] == LAST_ADDR) begin
               stat.done = 1'b1;
               cnt_in    = '0;
               state_in  = SW_IDLE;
            end
         end
         SW_RELABEL: begin
            // read entry k, write it back in the following cycle
            stat.busy  = 1'b1;
            stat.rd_en = !cnt_ff[ADDR_W];
            stat.wr_en = wpend_ff;
            if (stat.rd_en) begin
               cnt_in   = cnt_ff + 1'b1;
               wpend_in = 1'b1;
               waddr_in = cnt_ff[ADDR_W-1:0];
            end
            if (cnt_ff[ADDR_W] && wpend_ff) begin
               stat.done = 1'b1;
               cnt_in    = '0;
               state_in  = SW_IDLE;
            end
         end
         default: begin
            state_in = SW_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SW_INIT;
         cnt_ff   <= '0;
         wpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         wpend_ff <= wpend_in;
      end
      waddr_ff <= waddr_in;
   end

endmodule

`default_nettype wire

### rtl/spot_entry_update.sv
`default_nettype none

module spot_entry_update
   import spot_pkg::*;
(
   input  wire pair_entry_type      entry_cur,
   input  wire logic [EPOCH_W-1:0]  epoch,
   input  wire logic [POS_W-1:0]    left,
   output pair_entry_type           entry_new,
   output pair_status_type          status,
   output logic [POS_W-1:0]         link,
   output logic [COUNT_W-1:0]       count
);

   logic live;
   logic [COUNT_W-1:0] count_inc;

   // an entry from an earlier block reads as empty
   assign live = (entry_cur.tag == epoch);
   assign count_inc = (entry_cur.count < COUNT_MAX) ? entry_cur.count + 1'b1
                                                     : entry_cur.count;

   always_comb begin
      entry_new.tag = epoch;
      entry_new.pos = left;
      if (live && entry_cur.seen) begin
         // second sighting: pair becomes active
         entry_new.seen   = 1'b0;
         entry_new.active = 1'b1;
         entry_new.count  = COUNT_W'(2);
         status           = PS_ACTIVE;
         link             = entry_cur.pos;
         count            = COUNT_W'(2);
      end else if (live && entry_cur.active) begin
         entry_new.seen   = 1'b0;
         entry_new.active = 1'b1;
         entry_new.count  = count_inc;
         status           = PS_MORE;
         link             = entry_cur.pos;
         count            = count_inc;
      end else begin
         // first sighting
         entry_new.seen   = 1'b1;
         entry_new.active = 1'b0;
         entry_new.count  = '0;
         status           = PS_FIRST;
         link             = '0;
         count            = '0;
      end
   end

endmodule

`default_nettype wire

### rtl/symbol_pair_occurrence_tracker.sv
`default_nettype none
// An accepted req beat passes stage 1 (table read) and the output register (update) to its rsp beat.
// Throughput: 1 beat per cycle while rsp_tready holds; a pair repeated on back-to-back beats is forwarded.
// After every 2**EPOCH_W-2 blocks the next block start drains stage 1, then stalls while
// the sweep starts and runs a relabel pass, one entry per cycle.
// Reset is synchronous, active high; after it a clearing pass runs over all 2**(2*SYMBOL_BITS)
// pair table entries while req_tready stays low (csr writes are taken).

module symbol_pair_occurrence_tracker
   import spot_pkg::*;
#(
   parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // config
   input  wire logic          csr_we,
   input  wire logic [20:0]   csr_wdata,   // block_size
   // input stream
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // symbol[7:0]
   // result stream
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [87:0]        rsp_tdata,   // position[19:0], pair_position[39:20],
                                           // link_from[59:40], pair_count[80:60], zero
   output logic [1:0]         rsp_tuser,   // pair_status[1:0]
   output logic               rsp_tlast    // block_last
);

   localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
   localparam int ADDR_W = 2 * SYMBOL_BITS;
   localparam int BS_RESET = (CFG_RESET > MAX_BLOCK) ? MAX_BLOCK : CFG_RESET;

   // block size register, clamped on write
   logic [CNT_W-1:0] bs_ff, bs_in;

   always_comb begin
      if (csr_wdata < CFG_W'(2)) begin
         bs_in = CNT_W'(2);
      end else if (32'(csr_wdata) > 32'(MAX_BLOCK)) begin
         bs_in = CNT_W'(MAX_BLOCK);
      end else begin
         bs_in = CNT_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff <= CNT_W'(BS_RESET);
      end else if (csr_we) begin
         bs_ff <= bs_in;
      end
   end

   // front state
   logic [CNT_W-1:0]       cnt_ff;
   logic [SYMBOL_BITS-1:0] older_ff, newer_ff;
   logic                   skip_ff;
   logic [EPOCH_W-1:0]     epoch_ff;

   // stage 1 (table data arrives)
   logic                   s1_valid_ff;
   logic                   s1_op_ff;
   logic                   s1_last_ff;
   logic [POS_W-1:0]       s1_pos_ff;
   logic [POS_W-1:0]       s1_left_ff;
   logic [ADDR_W-1:0]      s1_key_ff;
   logic [EPOCH_W-1:0]     s1_epoch_ff;
   logic                   byp_hit_ff;
   pair_entry_type         byp_data_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_ppos_ff, rsp_link_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   pair_status_type        rsp_status_ff;
   logic                   rsp_last_ff;

   // table and sweep wiring
   sweep_stat_type         sw_stat;
   logic [ADDR_W-1:0]      sw_raddr, sw_waddr;
   pair_entry_type         sw_wdata;
   pair_entry_type         ram_rdata, ram_wdata;
   logic                   ram_we, ram_re;
   logic [ADDR_W-1:0]      ram_waddr, ram_raddr;

   // stage 0 decode
   logic                   blk_start;
   logic [CNT_W-1:0]       pos;
   logic [CNT_W-1:0]       pos_next;
   logic [SYMBOL_BITS-1:0] sym;
   logic                   skip;
   logic                   op;
   logic [ADDR_W-1:0]      key;
   logic [EPOCH_W-1:0]     epoch_item;
   logic                   wrap_wait;
   logic                   sweep_start;
   logic                   advance;
   logic                   accept;
   logic                   commit_we;

   assign sym        = req_tdata[SYMBOL_BITS-1:0];
   assign blk_start  = (cnt_ff == '0) || (cnt_ff >= bs_ff);
   assign pos        = blk_start ? '0 : cnt_ff;
   assign pos_next   = pos + 1'b1;
   assign epoch_item = blk_start ? epoch_ff + 1'b1 : epoch_ff;
   assign skip       = (pos > CNT_W'(1)) && (older_ff == newer_ff) &&
                       (newer_ff == sym) && !skip_ff;
   assign op         = (pos != '0) && !skip;
   assign key        = {newer_ff, sym};

   // a block start at the last tag value waits for the relabel pass
   assign wrap_wait   = blk_start && (epoch_ff == EPOCH_MAX);
   assign sweep_start = req_tvalid && wrap_wait && !sw_stat.busy && !s1_valid_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !sw_stat.busy && !wrap_wait && (!s1_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;
   assign commit_we  = s1_valid_ff && advance && s1_op_ff;

   // front state update
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         older_ff <= '0;
         newer_ff <= '0;
         skip_ff  <= 1'b0;
         epoch_ff <= EPOCH_ONE;
      end else begin
         if (sw_stat.done) begin
            epoch_ff <= EPOCH_ONE;
         end
         if (accept) begin
            cnt_ff   <= pos_next;
            epoch_ff <= epoch_item;
            older_ff <= (pos == '0) ? sym : newer_ff;
            newer_ff <= sym;
            if (pos == '0) begin
               skip_ff <= 1'b0;
            end else begin
               skip_ff <= skip;
            end
         end
      end
   end

   // table update for the item in stage 1
   pair_entry_type   entry_cur, entry_new;
   pair_status_type  upd_status;
   logic [POS_W-1:0] upd_link;
   logic [COUNT_W-1:0] upd_count;

   assign entry_cur = byp_hit_ff ? byp_data_ff : ram_rdata;

   spot_entry_update u_update (
      .entry_cur (entry_cur),
      .epoch     (s1_epoch_ff),
      .left      (s1_left_ff),
      .entry_new (entry_new),
      .status    (upd_status),
      .link      (upd_link),
      .count     (upd_count)
   );

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_op_ff    <= op;
         s1_last_ff  <= (pos_next >= bs_ff);
         s1_pos_ff   <= POS_W'(pos);
         s1_left_ff  <= POS_W'(pos - 1'b1);
         s1_key_ff   <= key;
         s1_epoch_ff <= epoch_item;
         // write landing on the same edge as this read
         byp_hit_ff  <= commit_we && (s1_key_ff == key);
         byp_data_ff <= entry_new;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (advance && s1_valid_ff) begin
         rsp_pos_ff  <= s1_pos_ff;
         rsp_last_ff <= s1_last_ff;
         if (s1_op_ff) begin
            rsp_status_ff <= upd_status;
            rsp_ppos_ff   <= s1_left_ff;
            rsp_link_ff   <= upd_link;
            rsp_count_ff  <= upd_count;
         end else begin
            rsp_status_ff <= PS_NONE;
            rsp_ppos_ff   <= '0;
            rsp_link_ff   <= '0;
            rsp_count_ff  <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_link_ff, rsp_ppos_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sweep sequencer
   spot_sweep #(
      .ADDR_W (ADDR_W)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .start   (sweep_start),
      .rd_data (ram_rdata),
      .stat    (sw_stat),
      .rd_addr (sw_raddr),
      .wr_addr (sw_waddr),
      .wr_data (sw_wdata)
   );

   // memory port muxing; sweep and item traffic never overlap
   assign ram_we    = sw_stat.wr_en || commit_we;
   assign ram_waddr = sw_stat.wr_en ? sw_waddr : s1_key_ff;
   assign ram_wdata = sw_stat.wr_en ? sw_wdata : entry_new;
   assign ram_re    = sw_stat.rd_en || accept;
   assign ram_raddr = sw_stat.busy ? sw_raddr : key;

   spot_pair_ram #(
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire

### tb/tb_symbol_pair_occurrence_tracker.sv
`timescale 1ns / 100ps

module tb_symbol_pair_occurrence_tracker;
   import spot_pkg::*;

   localparam int RUN_LIMIT   = 600000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 170;
   localparam int MAX_BLK     = MAX_BLOCK_DEF;

   // Block sizes for the random phases, including the clamped extremes
   localparam logic [20:0] PHASE_SIZES [9] = '{21'd3, 21'd2, 21'd64, 21'd7, 21'd1048576,
                                               21'd300, 21'd1, 21'h1FFFFF, 21'd20};

   // Directed streams: runs of equal symbols, repeats, field extremes
   localparam logic [7:0] RUN_BYTES [16] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00,
                                             8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'h5a,
                                             8'ha5, 8'h5a, 8'ha5, 8'h5a};
   localparam logic [7:0] TINY_BYTES [3] = '{8'h81, 8'h7e, 8'h81};
   localparam logic [7:0] LONG_BYTES [6] = '{8'hc3, 8'hc3, 8'hc3, 8'h3c, 8'hc3, 8'hc3};
   localparam logic [7:0] CUT_BYTES [2]  = '{8'h11, 8'h22};

   // Expected content of one result beat
   typedef struct packed {
      logic [POS_W-1:0]   position;
      pair_status_type    status;
      logic [POS_W-1:0]   pair_pos;
      logic [POS_W-1:0]   link;
      logic [COUNT_W-1:0] count;
      logic               last;
   } pair_report_type;

   // Predictor view of one pair table entry
   typedef struct packed {
      logic               seen;
      logic               active;
      logic [POS_W-1:0]   pos;
      logic [COUNT_W-1:0] count;
   } pair_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [20:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // Stimulus and scoreboard state
   logic [7:0]      pending_symbols[$];
   pair_report_type pair_reports_due[$];
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              holds_asked = 0;
   int              holds_done = 0;
   int              hold_left = 0;
   int              fail_count = 0;
   int              cycle_count = 0;
   int              symbols_taken = 0;
   int              status_hits[4] = '{0, 0, 0, 0};
   int              size_writes = 0;

   // Predictor state
   logic [20:0]     cfg_block_size = 21'(CFG_RESET);
   pair_slot_type   pair_slots[logic [15:0]];
   int              syms_in_block = 0;
   int              blocks_started = 0;
   logic [7:0]      older_sym = '0;
   logic [7:0]      newer_sym = '0;
   logic            skip_armed = 1'b0;

   symbol_pair_occurrence_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Advance the pair tracker by one symbol and return the beat it should produce
   function automatic pair_report_type track_pair(input logic [7:0] sym);
      int              eff;
      logic [15:0]     key;
      pair_slot_type   slot;
      pair_report_type rep;
      eff = int'(cfg_block_size);
      if (eff < 2) eff = 2;
      if (eff > MAX_BLK) eff = MAX_BLK;
      // block start empties the table
      if (syms_in_block == 0 || syms_in_block >= eff) begin
         pair_slots.delete();
         syms_in_block = 0;
         skip_armed = 1'b0;
         blocks_started++;
      end
      rep = '0;
      rep.position = POS_W'(syms_in_block);
      if (syms_in_block == 0) begin
         older_sym = sym;
         newer_sym = sym;
      end else begin
         // middle pair of three equal symbols is skipped
         if (syms_in_block >= 2 && older_sym == newer_sym && newer_sym == sym &&
             !skip_armed) begin
            skip_armed = 1'b1;
         end else begin
            key = {newer_sym, sym};
            rep.pair_pos = POS_W'(syms_in_block - 1);
            slot = pair_slots.exists(key) ? pair_slots[key] : '0;
            if (slot.seen) begin
               rep.status = PS_ACTIVE;
               rep.link = slot.pos;
               rep.count = COUNT_W'(2);
               slot.seen = 1'b0;
               slot.active = 1'b1;
               slot.count = COUNT_W'(2);
            end else if (slot.active) begin
               rep.status = PS_MORE;
               rep.link = slot.pos;
               if (slot.count != COUNT_MAX) slot.count = slot.count + 1'b1;
               rep.count = slot.count;
            end else begin
               rep.status = PS_FIRST;
               slot.seen = 1'b1;
            end
            slot.pos = POS_W'(syms_in_block - 1);
            pair_slots[key] = slot;
            skip_armed = 1'b0;
         end
         older_sym = newer_sym;
         newer_sym = sym;
      end
      syms_in_block++;
      rep.last = (syms_in_block >= eff);
      return rep;
   endfunction

   // Append one symbol to the send queue
   function automatic void add_symbol(input logic [7:0] sym);
      pending_symbols.insert(pending_symbols.size(), sym);
   endfunction

   // Append one prediction to the scoreboard
   function automatic void add_report(input pair_report_type rep);
      pair_reports_due.insert(pair_reports_due.size(), rep);
   endfunction

   // Sender: offers queued symbols, predicts on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            add_report(track_pair(req_tdata));
            symbols_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_symbols.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_symbols.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result beat against the oldest prediction
   always @(posedge clock) begin
      pair_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pair_reports_due.size() == 0) begin
               $error("result beat with no prediction pending");
               fail_count++;
            end else begin
               want = pair_reports_due.pop_front();
               status_hits[want.status]++;
               if (rsp_tdata[19:0] !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_tdata[19:0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("pair_status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[39:20] !== want.pair_pos) begin
                  $error("pair_position: expected %0d, got %0d", want.pair_pos,
                         rsp_tdata[39:20]);
                  fail_count++;
               end
               if (rsp_tdata[59:40] !== want.link) begin
                  $error("link_from: expected %0d, got %0d", want.link, rsp_tdata[59:40]);
                  fail_count++;
               end
               if (rsp_tdata[80:60] !== want.count) begin
                  $error("pair_count: expected %0d, got %0d", want.count, rsp_tdata[80:60]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("block_last: expected %0d, got %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         // long hold-off when asked, else random stalls
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Wait until no symbol is queued or in flight, then let the pipeline settle
   task automatic wait_drained();
      @(negedge clock);
      while (pending_symbols.size() != 0 || req_tvalid || pair_reports_due.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; only called while the block is idle
   task automatic write_block_size(input logic [20:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_block_size = value;
      size_writes++;
   endtask

   // Random symbols: mostly a small alphabet and repeats to build pairs and runs
   task automatic queue_random(input int n);
      logic [7:0] alphabet[4];
      logic [7:0] sym;
      int         pick;
      sym = '0;
      foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(255));
      @(negedge clock);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) sym = alphabet[$urandom_range(3)];
         else if (pick >= 65) sym = 8'($urandom_range(255));
         add_symbol(sym);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: sender light idling, receiver heavy
      send_idle_pct = 14;
      recv_idle_pct = 53;
      write_block_size(21'd16);
      foreach (RUN_BYTES[k]) add_symbol(RUN_BYTES[k]);
      wait_drained();
      write_block_size(21'd0);
      foreach (TINY_BYTES[k]) add_symbol(TINY_BYTES[k]);
      wait_drained();
      write_block_size(21'h1FFFFF);
      foreach (LONG_BYTES[k]) add_symbol(LONG_BYTES[k]);
      wait_drained();
      // lowering the size below the symbols taken forces a new block
      write_block_size(21'd3);
      foreach (CUT_BYTES[k]) add_symbol(CUT_BYTES[k]);
      wait_drained();

      // Random phases under three idling schemes
      for (int ph = 0; ph < 9; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 14;
            recv_idle_pct = 53;
         end else if (ph < 6) begin
            send_idle_pct = 53;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_block_size(PHASE_SIZES[ph]);
         if (ph == 4 || ph == 7) begin
            // receiver goes quiet while the sender keeps pushing
            @(negedge clock);
            holds_asked++;
         end
         if (ph == 5) begin
            // sender pause until all results are back, same setting
            queue_random(PHASE_ITEMS / 2);
            wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            queue_random(PHASE_ITEMS);
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d symbols in %0d blocks over %0d block-size writes",
               symbols_taken, blocks_started, size_writes);
      $display("Pair status mix: none %0d, first %0d, active %0d, further %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
